[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define LWS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lws: implication check failed");

// Implication whose consequent is checked at the next clock edge.
`define LWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lws: next-cycle check failed");

`endif

[rtl/lws_pkg.sv]
// ----------------------------------------------------------------------------
// lws_pkg
// Constants, types and helpers shared by the line word search block.
// ----------------------------------------------------------------------------
package lws_pkg;

	// Target word and line length limits.
	localparam int MAX_WORD          = 32;
	localparam int LINE_LENGTH_LIMIT = 4095;
	localparam int LEN_W             = 12;
	localparam int TLEN_W            = 6;
	localparam int WIN_IDX_W         = $clog2(MAX_WORD);

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CHARS_PER_REG = CFG_DATA_W / 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_SECOND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_THIRD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH     = 3'd4;

	// Line terminator codes.
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_EOF = 8'hFF;

	typedef logic [7:0] char_t;

	// Current target word as seen by the scanner.
	typedef struct packed {
		logic [TLEN_W-1:0]          target_length;
		logic [MAX_WORD-1:0][7:0]   target_chars;
	} cfg_t;

	// Running state of the line being scanned.
	typedef struct packed {
		logic             matched;
		logic [LEN_W-1:0] length;
	} line_status_t;

	// True for bytes that close a line.
	function automatic logic is_terminator(input char_t b);
		is_terminator = (b == CH_LF) || (b == CH_CR) || (b == CH_NUL) || (b == CH_EOF);
	endfunction

endpackage

[rtl/lws_if.sv]
// ----------------------------------------------------------------------------
// lws channel interfaces
// Valid/ready channels for text bytes in and line results out.
// ----------------------------------------------------------------------------

// Text byte channel.
interface lws_byte_if;
	logic                valid;
	logic                ready;
	lws_pkg::char_t      text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

// Line result channel.
interface lws_result_if;
	logic                        valid;
	logic                        ready;
	logic                        line_matched;
	logic [lws_pkg::LEN_W-1:0]   line_length;

	modport source (output valid, output line_matched, output line_length, input ready);
	modport sink   (input valid, input line_matched, input line_length, output ready);
endinterface

[rtl/lws_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lws_cfg_regs
// Write-only configuration registers holding the target word and its length.
// ----------------------------------------------------------------------------
module lws_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lws_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lws_pkg::cfg_t                      cfg
);

	logic [lws_pkg::TLEN_W-1:0]       target_length_q;
	logic [3:0][lws_pkg::CFG_DATA_W-1:0] chars_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_length_q <= '0;
			chars_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lws_pkg::REG_TARGET_LENGTH: target_length_q <= cfg_data[lws_pkg::TLEN_W-1:0];
				lws_pkg::REG_CHARS_LOW:     chars_q[0] <= cfg_data;
				lws_pkg::REG_CHARS_SECOND:  chars_q[1] <= cfg_data;
				lws_pkg::REG_CHARS_THIRD:   chars_q[2] <= cfg_data;
				lws_pkg::REG_CHARS_HIGH:    chars_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Character 0 sits in the lowest byte of the low register.
	assign cfg.target_length = target_length_q;
	assign cfg.target_chars  = chars_q;

endmodule

[rtl/lws_line_scan.sv]
// ----------------------------------------------------------------------------
// lws_line_scan
// Character window, line counter and sticky match flag for the current line.
// ----------------------------------------------------------------------------
module lws_line_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  lws_pkg::char_t        text_byte,
	input  lws_pkg::cfg_t         cfg,
	output lws_pkg::line_status_t status
);

	localparam int MW = lws_pkg::MAX_WORD;
	localparam int LW = lws_pkg::LEN_W;
	localparam int TW = lws_pkg::TLEN_W;

	lws_pkg::char_t              window_q [MW];
	lws_pkg::char_t              win_next [MW];
	logic [LW-1:0]               count_q;
	logic [LW-1:0]               count_next;
	logic                        match_q;
	logic [MW-1:0]               char_ok;
	logic                        len_ok;
	logic                        hit;
	logic                        term;

	assign term = lws_pkg::is_terminator(text_byte);

	// Window after shifting in the new byte; entry 0 is the newest.
	always_comb begin
		win_next[0] = text_byte;
		for (int j = 1; j < MW; j++) begin
			win_next[j] = window_q[j-1];
		end
	end

	// Line length after counting this byte, held at the limit.
	assign count_next = (count_q < LW'(lws_pkg::LINE_LENGTH_LIMIT)) ? count_q + LW'(1) : count_q;

	// Target character k lines up with the byte length-1-k places back.
	always_comb begin
		logic [TW-1:0] diff;
		for (int k = 0; k < MW; k++) begin
			diff = cfg.target_length - TW'(k + 1);
			if (TW'(k) >= cfg.target_length) begin
				char_ok[k] = 1'b1;
			end else begin
				char_ok[k] = (win_next[diff[lws_pkg::WIN_IDX_W-1:0]] == cfg.target_chars[k]);
			end
		end
	end

	// The line must already hold a whole target's worth of characters.
	assign len_ok = (cfg.target_length != '0) && (cfg.target_length <= TW'(MW)) &&
		(count_next >= LW'(cfg.target_length));
	assign hit = len_ok && (&char_ok);

	// Window shift; stale bytes are masked by the line count.
	always_ff @(posedge clk) begin
		if (go && !term) begin
			window_q <= win_next;
		end
	end

	// Line count and sticky match flag, cleared when a line closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= 1'b0;
		end else if (go) begin
			if (term) begin
				count_q <= '0;
				match_q <= 1'b0;
			end else begin
				count_q <= count_next;
				match_q <= match_q | hit;
			end
		end
	end

	assign status.matched = match_q;
	assign status.length  = count_q;

endmodule

[rtl/line_word_search.sv]
// ----------------------------------------------------------------------------
// line_word_search
// Per-line search of a text byte stream for a configured target word.
// ----------------------------------------------------------------------------
//  channel   dir  payload                     request
//  text      in   text_byte[7:0]              one text character
//  result    out  line_matched, line_length   one finished line
//  cfg       in   cfg_idx[2:0], cfg_data[63:0] one register write
//
// One byte per cycle sustained unless a terminator waits on a held result;
// a byte is taken into the input register and then updates the window or,
// for a terminator, loads the result register. The compare is combinational.
// Reset clears the line state, the configuration registers and both valid flags.
// A held result stalls only a following terminator; ordinary characters keep
// flowing into the window while the result waits.
// ----------------------------------------------------------------------------
module line_word_search (
	input  logic                             clk,
	input  logic                             arst_n,
	lws_byte_if.sink                         text,
	lws_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [lws_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lws_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lws_pkg::cfg_t         cfg;
	lws_pkg::line_status_t status;
	lws_pkg::line_status_t out_q;
	lws_pkg::char_t        byte_s1;
	logic                  valid_s1;
	logic                  term_s1;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  advance;

	lws_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	lws_line_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.text_byte (byte_s1),
		.cfg       (cfg),
		.status    (status)
	);

	// Stage handshake: a terminator waits for room in the result register.
	assign term_s1    = lws_pkg::is_terminator(byte_s1);
	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && (!term_s1 || out_free);
	assign text.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
		end
	end

	// Result register, loaded with the line state when the line closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term_s1) begin
			out_q <= status;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.line_matched = out_q.matched;
	assign result.line_length  = out_q.length;

endmodule

[rtl/lws_checker.sv]
// ----------------------------------------------------------------------------
// lws_checker
// Port-level checks on the line word search block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lws_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input lws_pkg::char_t              in_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_matched,
	input logic [lws_pkg::LEN_W-1:0]   out_length
);

	logic in_term_taken;

	// A terminator request taken on the input side.
	assign in_term_taken = in_valid && in_ready &&
		((in_byte == lws_pkg::CH_LF) || (in_byte == lws_pkg::CH_CR) ||
		 (in_byte == lws_pkg::CH_NUL) || (in_byte == lws_pkg::CH_EOF));

	// An empty line can never report a match.
	`LWS_ASSERT_IMPLIES(a_empty_no_match, out_valid && out_matched, out_length != '0)

	// No result is pending right after reset.
	`LWS_ASSERT_IMPLIES(a_reset_clears, $rose(arst_n), !out_valid)

	// A fresh result follows a terminator taken on the input side, by way of the input register.
	`LWS_ASSERT_IMPLIES(a_result_cause, $rose(out_valid), $past(in_term_taken, 2))

	// A stalled result holds its payload.
	`LWS_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
		out_valid && $stable(out_matched) && $stable(out_length))

endmodule

bind line_word_search lws_checker u_lws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (text.valid),
	.in_ready    (text.ready),
	.in_byte     (text.text_byte),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_matched (result.line_matched),
	.out_length  (result.line_length)
);
